// ===== hdl/rect_alpha_overlay_assert.svh =====
// ----------------------------------------------------------------------------
// rect_alpha_overlay_assert.svh
// Assertion macros for the rectangle overlay block. Define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef RECT_ALPHA_OVERLAY_ASSERT_SVH
`define RECT_ALPHA_OVERLAY_ASSERT_SVH

`ifndef ASSERT_OFF

// checked on every clock edge outside reset
`define RAO_ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define RAO_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RAO_ASSERT_SYNC(label, clk, rst, prop, msg)
`define RAO_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/rao_pkg.sv =====
// ----------------------------------------------------------------------------
// rao_pkg
// Shared widths, register map, reset values and types of the overlay block.
// ----------------------------------------------------------------------------
package rao_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CFG_W      = 13;
   localparam int WEIGHT_W   = 9;
   localparam int CH_W       = 8;
   localparam int NUM_LANES  = 3;
   localparam int COLOR_W    = NUM_LANES * CH_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int PROD_W     = CH_W + WEIGHT_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
   localparam logic [PROD_W-1:0]   ROUND_HALF  = 17'd128;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_LEFT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_TOP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_RIGHT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RECT_BOTTOM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_WEIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OVERLAY_COLOR = 3'd7;

   // reset values
   localparam logic [CFG_W-1:0]    RST_FRAME_WIDTH   = 13'd1920;
   localparam logic [CFG_W-1:0]    RST_FRAME_HEIGHT  = 13'd1080;
   localparam logic [CFG_W-1:0]    RST_RECT_LEFT     = 13'd640;
   localparam logic [CFG_W-1:0]    RST_RECT_TOP      = 13'd420;
   localparam logic [CFG_W-1:0]    RST_RECT_RIGHT    = 13'd1280;
   localparam logic [CFG_W-1:0]    RST_RECT_BOTTOM   = 13'd660;
   localparam logic [WEIGHT_W-1:0] RST_BLEND_WEIGHT  = 9'd192;
   localparam logic [COLOR_W-1:0]  RST_OVERLAY_COLOR = 24'h32001E;

   typedef struct packed {
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
      logic [CFG_W-1:0] rect_left;
      logic [CFG_W-1:0] rect_top;
      logic [CFG_W-1:0] rect_right;
      logic [CFG_W-1:0] rect_bottom;
   } geom_type;

   typedef struct packed {
      logic in_rect;
      logic frame_end;
   } flags_type;

   typedef logic [NUM_LANES-1:0][CH_W-1:0] pixel_type;

endpackage

// ===== hdl/rao_position.sv =====
// ----------------------------------------------------------------------------
// rao_position
// Column/row counters and rectangle test for the item on the input port.
// ----------------------------------------------------------------------------
module rao_position #(
   parameter int MAX_WIDTH  = rao_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rao_pkg::DEF_MAX_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                frame_start,
   input  rao_pkg::geom_type   geom,
   output rao_pkg::flags_type  flags
);

   localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CMPW = ((CW > rao_pkg::CFG_W) ? CW : rao_pkg::CFG_W) + 1;
   localparam int CMPH = ((RW > rao_pkg::CFG_W) ? RW : rao_pkg::CFG_W) + 1;

   logic [CW-1:0]   col_ff, col_in, col_cur;
   logic [RW-1:0]   row_ff, row_in, row_cur;
   logic [CMPW-1:0] w_eff, col_x, fw_x;
   logic [CMPH-1:0] h_eff, row_x, fh_x;
   logic            last_col, last_row, in_x, in_y;

   always_comb begin
      // clamp frame size to 1..MAX
      fw_x = CMPW'(geom.frame_width);
      fh_x = CMPH'(geom.frame_height);
      if (fw_x == '0) begin
         w_eff = CMPW'(1);
      end else if (fw_x > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = fw_x;
      end
      if (fh_x == '0) begin
         h_eff = CMPH'(1);
      end else if (fh_x > CMPH'(MAX_HEIGHT)) begin
         h_eff = CMPH'(MAX_HEIGHT);
      end else begin
         h_eff = fh_x;
      end

      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      col_x   = CMPW'(col_cur);
      row_x   = CMPH'(row_cur);

      last_col = (col_x + CMPW'(1)) >= w_eff;
      last_row = (row_x + CMPH'(1)) >= h_eff;

      in_x = (col_x >= CMPW'(geom.rect_left)) && (col_x < CMPW'(geom.rect_right));
      in_y = (row_x >= CMPH'(geom.rect_top))  && (row_x < CMPH'(geom.rect_bottom));

      flags.in_rect   = in_x && in_y;
      flags.frame_end = last_col && last_row;

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_cur + RW'(1);
      end else begin
         col_in = col_cur + CW'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hdl/rao_lane.sv =====
// ----------------------------------------------------------------------------
// rao_lane
// One channel of the blend: (src*(256-a) + color*a + 128) >> 8.
// ----------------------------------------------------------------------------
module rao_lane (
   input  logic [rao_pkg::CH_W-1:0]     src,
   input  logic [rao_pkg::CH_W-1:0]     color,
   input  logic [rao_pkg::WEIGHT_W-1:0] weight,
   output logic [rao_pkg::CH_W-1:0]     blended
);

   logic [rao_pkg::WEIGHT_W-1:0] inv_weight;
   logic [rao_pkg::PROD_W-1:0]   prod_src, prod_col, sum;

   always_comb begin
      inv_weight = rao_pkg::WEIGHT_FULL - weight;
      prod_src   = rao_pkg::PROD_W'(src)   * rao_pkg::PROD_W'(inv_weight);
      prod_col   = rao_pkg::PROD_W'(color) * rao_pkg::PROD_W'(weight);
      sum        = prod_src + prod_col + rao_pkg::ROUND_HALF;
      // sum stays below 2^16, so the top bit is never set
      blended    = sum[rao_pkg::CH_W +: rao_pkg::CH_W];
   end

endmodule

// ===== hdl/rao_merge.sv =====
// ----------------------------------------------------------------------------
// rao_merge
// Picks blended or source channels per item and holds the result register.
// ----------------------------------------------------------------------------
module rao_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rao_pkg::pixel_type        src,
   input  rao_pkg::pixel_type        blended,
   input  rao_pkg::flags_type        flags,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [rao_pkg::CH_W-1:0]  rsp_result_ch0,
   output logic [rao_pkg::CH_W-1:0]  rsp_result_ch1,
   output logic [rao_pkg::CH_W-1:0]  rsp_result_ch2,
   output logic                      rsp_inside_rect,
   output logic                      rsp_frame_end
);

   logic               out_valid_ff;
   rao_pkg::pixel_type out_pix_ff, out_pix_in;
   rao_pkg::flags_type out_flags_ff;

   assign in_ready   = !out_valid_ff || !rsp_stall;
   assign out_pix_in = flags.in_rect ? blended : src;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         out_pix_ff   <= out_pix_in;
         out_flags_ff <= flags;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_ch0  = out_pix_ff[0];
   assign rsp_result_ch1  = out_pix_ff[1];
   assign rsp_result_ch2  = out_pix_ff[2];
   assign rsp_inside_rect = out_flags_ff.in_rect;
   assign rsp_frame_end   = out_flags_ff.frame_end;

endmodule

// ===== hdl/rect_alpha_overlay.sv =====
// ----------------------------------------------------------------------------
// rect_alpha_overlay
// Alpha-blends a configured colour into a rectangle of a raster pixel stream.
//  - req_*: one pixel item per cycle, raster order, while req_stall is low;
//    req_frame_start zeroes the column/row counters for its own item.
//  - rsp_*: one result item per input item, same order: channels, inside
//    flag, and frame_end on the last column of the last row.
//  - csr_*: write-only register port, taken on any edge with csr_we high;
//    write only while no item is in flight.
//  - Items pass stage 1, then the result register; throughput one item per
//    cycle unless stalled, two-stage pipe (position stage, lanes + result reg).
//  - rsp_stall holds the result register; stage 1 still takes one more item
//    if it is empty, and once it is full req_stall follows rsp_stall in the
//    same cycle.
//  - Synchronous reset empties the pipe, zeroes counters and loads the
//    register defaults (1920x1080, rect 640..1280 x 420..660, weight 192).
// ----------------------------------------------------------------------------
`include "rect_alpha_overlay_assert.svh"

module rect_alpha_overlay #(
   parameter int MAX_WIDTH  = rao_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rao_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rao_pkg::CH_W-1:0]         req_pixel_ch0,
   input  logic [rao_pkg::CH_W-1:0]         req_pixel_ch1,
   input  logic [rao_pkg::CH_W-1:0]         req_pixel_ch2,
   input  logic                             req_frame_start,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rao_pkg::CH_W-1:0]         rsp_result_ch0,
   output logic [rao_pkg::CH_W-1:0]         rsp_result_ch1,
   output logic [rao_pkg::CH_W-1:0]         rsp_result_ch2,
   output logic                             rsp_inside_rect,
   output logic                             rsp_frame_end,
   // register writes
   input  logic                             csr_we,
   input  logic [rao_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rao_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------- configuration registers ----------------
   rao_pkg::geom_type                geom_ff;
   logic [rao_pkg::WEIGHT_W-1:0]     weight_ff;
   logic [rao_pkg::COLOR_W-1:0]      color_ff;
   logic [rao_pkg::WEIGHT_W-1:0]     weight_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.frame_width  <= rao_pkg::RST_FRAME_WIDTH;
         geom_ff.frame_height <= rao_pkg::RST_FRAME_HEIGHT;
         geom_ff.rect_left    <= rao_pkg::RST_RECT_LEFT;
         geom_ff.rect_top     <= rao_pkg::RST_RECT_TOP;
         geom_ff.rect_right   <= rao_pkg::RST_RECT_RIGHT;
         geom_ff.rect_bottom  <= rao_pkg::RST_RECT_BOTTOM;
         weight_ff            <= rao_pkg::RST_BLEND_WEIGHT;
         color_ff             <= rao_pkg::RST_OVERLAY_COLOR;
      end else if (csr_we) begin
         case (csr_index)
            rao_pkg::REG_FRAME_WIDTH: begin
               geom_ff.frame_width <= csr_wdata[rao_pkg::CFG_W-1:0];
            end
            rao_pkg::REG_FRAME_HEIGHT: begin
               geom_ff.frame_height <= csr_wdata[rao_pkg::CFG_W-1:0];
            end
            rao_pkg::REG_RECT_LEFT: begin
               geom_ff.rect_left <= csr_wdata[rao_pkg::CFG_W-1:0];
            end
            rao_pkg::REG_RECT_TOP: begin
               geom_ff.rect_top <= csr_wdata[rao_pkg::CFG_W-1:0];
            end
            rao_pkg::REG_RECT_RIGHT: begin
               geom_ff.rect_right <= csr_wdata[rao_pkg::CFG_W-1:0];
            end
            rao_pkg::REG_RECT_BOTTOM: begin
               geom_ff.rect_bottom <= csr_wdata[rao_pkg::CFG_W-1:0];
            end
            rao_pkg::REG_BLEND_WEIGHT: begin
               weight_ff <= csr_wdata[rao_pkg::WEIGHT_W-1:0];
            end
            rao_pkg::REG_OVERLAY_COLOR: begin
               color_ff <= csr_wdata[rao_pkg::COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // weight above full scale saturates to full overlay colour
   assign weight_eff = (weight_ff > rao_pkg::WEIGHT_FULL) ? rao_pkg::WEIGHT_FULL : weight_ff;

   // ---------------- handshake ----------------
   logic s1_valid_ff;
   logic merge_ready;
   logic s1_ready;
   logic req_take;

   assign s1_ready  = !s1_valid_ff || merge_ready;
   assign req_stall = !s1_ready;
   assign req_take  = req_valid && s1_ready;

   // ---------------- stage 1: position ----------------
   rao_pkg::flags_type pos_flags;
   rao_pkg::flags_type s1_flags_ff;
   rao_pkg::pixel_type s1_src_ff;

   rao_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_take),
      .frame_start (req_frame_start),
      .geom        (geom_ff),
      .flags       (pos_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         s1_src_ff   <= {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
         s1_flags_ff <= pos_flags;
      end
   end

   // ---------------- stage 2: blend lanes ----------------
   rao_pkg::pixel_type lane_out;

   for (genvar g = 0; g < rao_pkg::NUM_LANES; g++) begin : g_lane
      rao_lane u_lane (
         .src     (s1_src_ff[g]),
         .color   (color_ff[g*rao_pkg::CH_W +: rao_pkg::CH_W]),
         .weight  (weight_eff),
         .blended (lane_out[g])
      );
   end

   // ---------------- merge + result register ----------------
   rao_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff),
      .in_ready        (merge_ready),
      .src             (s1_src_ff),
      .blended         (lane_out),
      .flags           (s1_flags_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_ch0  (rsp_result_ch0),
      .rsp_result_ch1  (rsp_result_ch1),
      .rsp_result_ch2  (rsp_result_ch2),
      .rsp_inside_rect (rsp_inside_rect),
      .rsp_frame_end   (rsp_frame_end)
   );

   // ---------------- assertions ----------------
   // an accepted item is always held in stage 1 on the next cycle
   `RAO_ASSERT_SYNC(a_take_lands, clock, reset, req_take |=> s1_valid_ff, "accepted item lost in stage 1")
   // a delivered result with nothing behind it leaves the output empty
   `RAO_ASSERT_SYNC(a_drain, clock, reset, (rsp_valid && !rsp_stall && !s1_valid_ff) |=> !rsp_valid, "result repeated")
   // zero weight reproduces the source channel exactly
   `RAO_ASSERT_SYNC(a_zero_weight, clock, reset, (s1_valid_ff && weight_eff == '0) |-> (lane_out[0] == s1_src_ff[0]), "zero weight")
   // the pipe is empty after reset
   `RAO_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - rectangle alpha overlay testbench
// Streams raster pixel items through rect_alpha_overlay under a series of
// register settings. Each accepted pixel is predicted locally from a private
// copy of the counters and registers. Each result item is checked field by
// field against the oldest prediction. Both handshakes idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_top;
   import rao_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000; // quiet cycles before giving up
   localparam int DRAIN_CYCLES   = 8;    // pipe is two deep, allow margin
   localparam int RANDOM_PHASES  = 12;

   typedef struct packed {
      logic [CH_W-1:0] ch0;
      logic [CH_W-1:0] ch1;
      logic [CH_W-1:0] ch2;
      logic            frame_start;
   } pixel_in_t;

   typedef struct packed {
      logic [CH_W-1:0] ch0;
      logic [CH_W-1:0] ch1;
      logic [CH_W-1:0] ch2;
      logic            in_rect;
      logic            frame_end;
   } overlay_out_t;

   typedef struct packed {
      logic [CFG_W-1:0]    width;
      logic [CFG_W-1:0]    height;
      logic [CFG_W-1:0]    left;
      logic [CFG_W-1:0]    top;
      logic [CFG_W-1:0]    right;
      logic [CFG_W-1:0]    bottom;
      logic [WEIGHT_W-1:0] weight;
      logic [COLOR_W-1:0]  color;
   } overlay_cfg_t;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

   // ---------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic [CH_W-1:0]       req_pixel_ch0   = '0;
   logic [CH_W-1:0]       req_pixel_ch1   = '0;
   logic [CH_W-1:0]       req_pixel_ch2   = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_stall       = 1'b0;
   logic                  csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic [CH_W-1:0]       rsp_result_ch0;
   logic [CH_W-1:0]       rsp_result_ch1;
   logic [CH_W-1:0]       rsp_result_ch2;
   logic                  rsp_inside_rect;
   logic                  rsp_frame_end;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   rect_alpha_overlay DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_ch0   (req_pixel_ch0),
      .req_pixel_ch1   (req_pixel_ch1),
      .req_pixel_ch2   (req_pixel_ch2),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_ch0  (rsp_result_ch0),
      .rsp_result_ch1  (rsp_result_ch1),
      .rsp_result_ch2  (rsp_result_ch2),
      .rsp_inside_rect (rsp_inside_rect),
      .rsp_frame_end   (rsp_frame_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // overlay prediction: private registers and raster position
   // ---------------------------------------------------------------------
   overlay_cfg_t cfg_now = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_RECT_LEFT,
                             RST_RECT_TOP, RST_RECT_RIGHT, RST_RECT_BOTTOM,
                             RST_BLEND_WEIGHT, RST_OVERLAY_COLOR};
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   pixel_in_t    pending_px[$];   // pixels waiting for the driver
   overlay_out_t expected_px[$];  // predicted results, oldest first

   int fail_count      = 0;
   int pixels_sent     = 0;
   int results_checked = 0;
   int inside_seen     = 0;
   int frame_ends_seen = 0;
   int settings_used   = 0;
   int input_stalls    = 0;
   int long_holds      = 0;
   int gen_pos         = 0;

   // frame size as the block sees it: zero becomes one, too large is capped
   function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned max_v);
      if (v == 0) return 1;
      if (v > max_v) return max_v;
      return 32'(v);
   endfunction

   function automatic logic [CH_W-1:0] blend_lane(logic [CH_W-1:0] src,
                                                  logic [CH_W-1:0] color,
                                                  int unsigned a);
      int unsigned sum;
      sum = src * (256 - a) + color * a + 128;
      return sum[2*CH_W-1:CH_W];
   endfunction

   // works out one result and advances the raster position
   function automatic overlay_out_t overlay_pixel(pixel_in_t px);
      overlay_out_t r;
      int unsigned  w, h, a;
      logic         last_col, last_row;
      w = eff_size(cfg_now.width, DEF_MAX_WIDTH);
      h = eff_size(cfg_now.height, DEF_MAX_HEIGHT);
      a = 32'((cfg_now.weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg_now.weight);
      if (px.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      r.in_rect = col_pos >= cfg_now.left && col_pos < cfg_now.right &&
                  row_pos >= cfg_now.top && row_pos < cfg_now.bottom;
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      r.ch0 = px.ch0;
      r.ch1 = px.ch1;
      r.ch2 = px.ch2;
      if (r.in_rect) begin
         r.ch0 = blend_lane(px.ch0, cfg_now.color[CH_W-1:0], a);
         r.ch1 = blend_lane(px.ch1, cfg_now.color[2*CH_W-1:CH_W], a);
         r.ch2 = blend_lane(px.ch2, cfg_now.color[3*CH_W-1:2*CH_W], a);
      end
      r.frame_end = last_col && last_row;
      // a position past a shrunk frame counts as the last one and wraps
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // driver: bursts of random length with random gaps; once offered, an
   // item stays on the wire unchanged until taken
   // ---------------------------------------------------------------------
   pixel_in_t on_wire   = '0;
   int        burst_left = 0;
   int        gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_px.push_back(overlay_pixel(on_wire));
            pixels_sent++;
         end
         if (req_valid && req_stall)
            input_stalls++;
         if (!req_valid || !req_stall) begin
            if (burst_left == 0) begin
               if ($urandom_range(0, 4) == 0) begin
                  burst_left = 120;     // a long unbroken run
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = $urandom_range(0, 8);
               end
            end
            if (gap_left > 0 || pending_px.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               on_wire = pending_px.pop_front();
               req_valid       <= 1'b1;
               req_pixel_ch0   <= on_wire.ch0;
               req_pixel_ch1   <= on_wire.ch1;
               req_pixel_ch2   <= on_wire.ch2;
               req_frame_start <= on_wire.frame_start;
               burst_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern changes in windows of random length; now and
   // then a long hold-off, timed here, so the pipe fills and req_stall rises
   // ---------------------------------------------------------------------
   stall_mode_t stall_mode   = STALL_NONE;
   int          mode_left    = 0;
   int          hold_left    = 0;
   int          taken        = 0;
   int          next_hold_at = 200;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && taken >= next_hold_at) begin
            hold_left    = $urandom_range(40, 64);
            next_hold_at = next_hold_at + 350;
            long_holds++;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_t'($urandom_range(0, 3));
               mode_left  = $urandom_range(8, 40);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every taken result against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   overlay_out_t exp_res;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_px.size() == 0) begin
            $error("result item with no pixel outstanding");
            fail_count++;
         end else begin
            exp_res = expected_px.pop_front();
            check_field("result_ch0", exp_res.ch0, rsp_result_ch0);
            check_field("result_ch1", exp_res.ch1, rsp_result_ch1);
            check_field("result_ch2", exp_res.ch2, rsp_result_ch2);
            check_field("inside_rect", exp_res.in_rect, rsp_inside_rect);
            check_field("frame_end", exp_res.frame_end, rsp_frame_end);
            inside_seen     += exp_res.in_rect;
            frame_ends_seen += exp_res.frame_end;
         end
         results_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any item or register write moving
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // checked mid-cycle so nothing races the clocked processes
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_px.size() != 0 || req_valid || expected_px.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // narrow registers sometimes get junk above their width; it must be dropped
   function automatic logic [CSR_DATA_W-1:0] with_junk(logic [CSR_DATA_W-1:0] v, int bits);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      return (junk << bits) | v;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // only called with the block idle
   task automatic load_config(overlay_cfg_t c);
      write_reg(REG_FRAME_WIDTH,   with_junk(c.width, CFG_W));
      write_reg(REG_FRAME_HEIGHT,  with_junk(c.height, CFG_W));
      write_reg(REG_RECT_LEFT,     with_junk(c.left, CFG_W));
      write_reg(REG_RECT_TOP,      with_junk(c.top, CFG_W));
      write_reg(REG_RECT_RIGHT,    with_junk(c.right, CFG_W));
      write_reg(REG_RECT_BOTTOM,   with_junk(c.bottom, CFG_W));
      write_reg(REG_BLEND_WEIGHT,  with_junk(c.weight, WEIGHT_W));
      write_reg(REG_OVERLAY_COLOR, c.color);
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_now = c;
      settings_used++;
   endtask

   function automatic logic [CH_W-1:0] rand_chan();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom);
      endcase
   endfunction

   // pattern of extremes, mid values and random channels for the directed items
   task automatic push_pattern(int n, bit open_frame);
      pixel_in_t px;
      for (int i = 0; i < n; i++) begin
         case (i % 4)
            0:       px = '{8'hFF, 8'hFF, 8'hFF, 1'b0};
            1:       px = '{8'h00, 8'h00, 8'h00, 1'b0};
            2:       px = '{8'h80, 8'h7F, 8'h01, 1'b0};
            default: px = '{rand_chan(), rand_chan(), rand_chan(), 1'b0};
         endcase
         px.frame_start = open_frame && (i == 0);
         pending_px.push_back(px);
      end
   endtask

   // mostly well-formed frames with random content, a few stray frame starts
   // and missing ones
   task automatic push_frames(int n);
      pixel_in_t   px;
      int unsigned fsize;
      fsize = eff_size(cfg_now.width, DEF_MAX_WIDTH) *
              eff_size(cfg_now.height, DEF_MAX_HEIGHT);
      gen_pos = 0;
      for (int i = 0; i < n; i++) begin
         px.ch0 = rand_chan();
         px.ch1 = rand_chan();
         px.ch2 = rand_chan();
         if (gen_pos == 0)
            px.frame_start = ($urandom_range(0, 9) != 0);
         else
            px.frame_start = ($urandom_range(0, 49) == 0);
         if (px.frame_start)
            gen_pos = 0;
         gen_pos = (gen_pos + 1) % fsize;
         pending_px.push_back(px);
      end
   endtask

   // rectangle span along one axis: usually inside the frame, sometimes
   // anywhere in the register's range, sometimes empty
   function automatic void pick_span(int unsigned span, output logic [CFG_W-1:0] lo,
                                     output logic [CFG_W-1:0] hi);
      int unsigned a;
      case ($urandom_range(0, 6))
         0: begin
            lo = CFG_W'($urandom);
            hi = CFG_W'($urandom);
         end
         1: begin
            a  = $urandom_range(0, span + 1);
            lo = CFG_W'(a);
            hi = CFG_W'($urandom_range(0, a));
         end
         default: begin
            a  = $urandom_range(0, span);
            lo = CFG_W'(a);
            hi = CFG_W'($urandom_range(a, span + 1));
         end
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] rand_size(int unsigned typical);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CFG_W'($urandom_range(4096, 8191));
         2:       return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(1, typical));
      endcase
   endfunction

   function automatic overlay_cfg_t random_setting(int k);
      overlay_cfg_t c;
      c.width  = rand_size(12);
      c.height = rand_size(6);
      pick_span(eff_size(c.width, DEF_MAX_WIDTH), c.left, c.right);
      pick_span(eff_size(c.height, DEF_MAX_HEIGHT), c.top, c.bottom);
      c.weight = WEIGHT_W'($urandom);
      c.color  = COLOR_W'($urandom);
      // the first few settings pin the weight and colour extremes
      case (k)
         0: begin
            c.weight = WEIGHT_FULL;
            c.color  = '1;
         end
         1: begin
            c.weight = '0;
            c.color  = '0;
         end
         2: c.weight = '1;
         default: ;
      endcase
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // the run
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: the first pixels sit at the frame origin, outside
      push_pattern(2, 1'b1);
      wait_idle();

      // small frame, rectangle in its middle, full overlay weight
      load_config('{13'd6, 13'd5, 13'd1, 13'd1, 13'd4, 13'd3, WEIGHT_FULL, 24'hFFFFFF});
      push_pattern(15, 1'b1);
      wait_idle();

      // shrink the frame under the running counters (column 3, row 2) with
      // no frame start; empty rectangle, weight far above full
      load_config('{13'd2, 13'd2, 13'd3, 13'd0, 13'd1, 13'd2, 9'h1FF, 24'h000000});
      push_pattern(3, 1'b0);
      wait_idle();

      // zero frame size is taken as one pixel; weight just above full
      load_config('{13'd0, 13'd0, 13'd0, 13'd0, 13'd1, 13'd1, 9'h101, 24'hA55AFF});
      push_pattern(3, 1'b1);
      wait_idle();

      // oversize frame is capped; rectangle wholly past the frame, zero weight
      load_config('{13'h1FFF, 13'd4096, 13'd4096, 13'd0, 13'h1FFF, 13'h1FFF,
                    9'd0, 24'h123456});
      push_pattern(2, 1'b1);
      wait_idle();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         load_config(random_setting(k));
         push_frames($urandom_range(95, 105));
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_px.size() != 0) begin
         $error("%0d predicted results never arrived", expected_px.size());
         fail_count++;
      end

      $display("Covered %0d pixels over %0d register settings: %0d results checked, %0d inside",
               pixels_sent, settings_used, results_checked, inside_seen);
      $display("  %0d frame ends, %0d input stall cycles, %0d long output hold-offs",
               frame_ends_seen, input_stalls, long_holds);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
